/* design/mbrr_pkg.sv */
// Types, codes and frame helpers shared by the Modbus read request and reply block.
package mbrr_pkg;

  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_RX   = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;

  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_READING = 1'b1;

  localparam logic [7:0]  FN_READ_INPUT  = 8'h04;
  localparam logic [7:0]  LINE_FEED      = 8'h0A;
  localparam int unsigned MIN_FAIL_COUNT = 5;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  typedef struct packed {
    logic       init;
    logic       step;
    logic       absorb;
    logic [7:0] data;
  } crc_ctrl_t;

  function automatic logic [7:0] reg_addr(input logic [1:0] q);
    logic [7:0] a;
    unique case (q)
      2'd0: a = 8'h00;
      2'd1: a = 8'h01;
      2'd2: a = 8'h02;
      default: a = 8'h04;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] reg_words(input logic [1:0] q);
    return q[1] ? 8'h02 : 8'h01;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [7:0] id,
                                            input logic [1:0] q, input logic [15:0] crc);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = id;
      3'd1: b = FN_READ_INPUT;
      3'd2: b = 8'h00;
      3'd3: b = reg_addr(q);
      3'd4: b = 8'h00;
      3'd5: b = reg_words(q);
      3'd6: b = crc[7:0];
      default: b = crc[15:8];
    endcase
    return b;
  endfunction

endpackage

/* design/mbrr_in_if.sv */
// Request channel interface: command, quantity, device id and received byte.
interface mbrr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] quantity;
  logic [7:0] device_id;
  logic [7:0] rx_byte;

  modport source (output valid, func, quantity, device_id, rx_byte, input ready);
  modport sink (input valid, func, quantity, device_id, rx_byte, output ready);
endinterface

/* design/mbrr_out_if.sv */
// Result channel interface: transmit bytes and readings.
interface mbrr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        frame_last;
  logic        ok;
  logic [1:0]  reading_quantity;
  logic [31:0] raw_value;

  modport source (output valid, kind, tx_byte, frame_last, ok, reading_quantity, raw_value,
                  input ready);
  modport sink (input valid, kind, tx_byte, frame_last, ok, reading_quantity, raw_value,
                output ready);
endinterface

/* design/mbrr_crc.sv */
// Bit-serial CRC-16/MODBUS unit that advances one bit per step.
module mbrr_crc (
  input  logic               clk,
  input  logic               rst,
  input  mbrr_pkg::crc_ctrl_t ctrl,
  output logic [15:0]        crc
);
  import mbrr_pkg::*;

  logic [15:0] mixed;

  assign mixed = ctrl.absorb ? (crc ^ {8'h00, ctrl.data}) : crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (ctrl.init) begin
      crc <= CRC_INIT;
    end else if (ctrl.step) begin
      crc <= mixed[0] ? ((mixed >> 1) ^ CRC_POLY) : (mixed >> 1);
    end
  end
endmodule

/* design/modbus_read_request_and_reply.sv */
// Modbus RTU read-input-register master: request frame builder and reply decoder.
// A request runs a bit-serial CRC over the six header bytes, then sends 8 bytes at one per cycle
// while the result sink is ready; no new input is taken until the last byte has been taken.
// A received byte is counted as it is taken; closing a reply registers one reading as the result.
// The input is not ready while a request is in progress or a result is held.
// Synchronous reset clears the reply count, pending quantity, stored bytes and result valid.
module modbus_read_request_and_reply #(
  parameter int REPLY_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  mbrr_in_if.sink       request,
  mbrr_out_if.source    result
);
  import mbrr_pkg::*;

  localparam int CW = $clog2(REPLY_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CRC  = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0]    state;
  logic [2:0]    bit_cnt;
  logic [2:0]    byte_cnt;
  logic [1:0]    pend_q;
  logic [7:0]    dev_id;
  logic [CW-1:0] count;
  logic [7:0]    store [4];
  logic [7:0]    store_next [4];
  logic [15:0]   crc;
  crc_ctrl_t     crc_ctrl;
  logic          in_xfer;
  logic          out_free;
  logic          room;
  logic          closing;
  logic          ok_next;
  logic [31:0]   raw_next;

  assign request.ready = (state == ST_IDLE) && !result.valid;
  assign in_xfer       = request.valid && request.ready;
  assign out_free      = !result.valid || result.ready;
  assign room          = count < CW'(REPLY_DEPTH);
  assign closing       = in_xfer && ((request.func == FUNC_END) ||
                         (request.func == FUNC_RX && request.rx_byte == LINE_FEED));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      store_next[i] = store[i];
      if (in_xfer && request.func == FUNC_RX && room && count == CW'(i + 3)) begin
        store_next[i] = request.rx_byte;
      end
    end
    ok_next  = count > CW'(MIN_FAIL_COUNT);
    raw_next = 32'd0;
    if (ok_next) begin
      raw_next = pend_q[1] ? {store_next[0], store_next[1], store_next[2], store_next[3]}
                           : {16'h0000, store_next[0], store_next[1]};
    end
  end

  always_comb begin
    crc_ctrl.init   = in_xfer && request.func == FUNC_SEND;
    crc_ctrl.step   = state == ST_CRC;
    crc_ctrl.absorb = bit_cnt == 3'd0;
    crc_ctrl.data   = frame_byte(byte_cnt, dev_id, pend_q, crc);
  end

  mbrr_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .crc  (crc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bit_cnt      <= 3'd0;
      byte_cnt     <= 3'd0;
      pend_q       <= 2'd0;
      dev_id       <= 8'h00;
      count        <= '0;
      result.valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        store[i] <= 8'h00;
      end
    end else begin
      store <= store_next;
      if (result.valid && result.ready && state != ST_SEND) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (request.func == FUNC_SEND) begin
              pend_q   <= request.quantity;
              dev_id   <= request.device_id;
              count    <= '0;
              bit_cnt  <= 3'd0;
              byte_cnt <= 3'd0;
              state    <= ST_CRC;
            end else if (closing) begin
              count                   <= '0;
              result.valid            <= 1'b1;
              result.kind             <= KIND_READING;
              result.tx_byte          <= 8'h00;
              result.frame_last       <= 1'b1;
              result.ok               <= ok_next;
              result.reading_quantity <= pend_q;
              result.raw_value        <= raw_next;
            end else if (request.func == FUNC_RX && room) begin
              count <= count + CW'(1);
            end
          end
        end
        ST_CRC: begin
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            if (byte_cnt == 3'd5) begin
              byte_cnt <= 3'd0;
              state    <= ST_SEND;
            end else begin
              byte_cnt <= byte_cnt + 3'd1;
            end
          end
        end
        ST_SEND: begin
          if (out_free) begin
            result.valid            <= 1'b1;
            result.kind             <= KIND_TX;
            result.tx_byte          <= frame_byte(byte_cnt, dev_id, pend_q, crc);
            result.frame_last       <= byte_cnt == 3'd7;
            result.ok               <= 1'b0;
            result.reading_quantity <= pend_q;
            result.raw_value        <= 32'd0;
            byte_cnt                <= byte_cnt + 3'd1;
            if (byte_cnt == 3'd7) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

/* dv/meter_tb_pkg.sv */
// Quantity codes and sizes shared by the meter request and reply testbench files.
`timescale 1ns / 100ps
package meter_tb_pkg;

  localparam logic [1:0] QTY_VOLTAGE = 2'd0;
  localparam logic [1:0] QTY_CURRENT = 2'd1;
  localparam logic [1:0] QTY_POWER   = 2'd2;
  localparam logic [1:0] QTY_ENERGY  = 2'd3;

  localparam logic [1:0] FUNC_IGNORED = 2'd3;

  localparam int REPLY_SLOTS = 16;

endpackage

/* dv/meter_reply_checker.sv */
// Checker that predicts request frames and meter readings and compares them with the results.
`timescale 1ns / 100ps
module meter_reply_checker (
  input  logic        clk,
  input  logic        rst,
  mbrr_in_if          request,
  mbrr_out_if         result,
  output int unsigned error_count,
  output int unsigned expected_count
);
  import mbrr_pkg::*;
  import meter_tb_pkg::*;

  typedef struct {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        frame_last;
    logic        ok;
    logic [1:0]  qty;
    logic [31:0] raw;
  } meter_result_t;

  meter_result_t awaited_results[$];
  logic [7:0]    reply_bytes[REPLY_SLOTS];
  int unsigned   reply_len;
  logic [1:0]    awaited_qty;
  int unsigned   fails = 0;
  int unsigned   queued = 0;

  assign error_count    = fails;
  assign expected_count = queued;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fails++;
  endtask

  function automatic logic [15:0] modbus_crc(input logic [47:0] frame);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 5; i >= 0; i--) begin
      crc = crc ^ {8'h00, frame[i*8 +: 8]};
      for (int k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  task automatic predict_request(input logic [1:0] qty, input logic [7:0] id);
    logic [7:0]    reg_start;
    logic [7:0]    reg_count;
    logic [47:0]   head;
    logic [15:0]   crc;
    logic [63:0]   frame;
    meter_result_t item;
    case (qty)
      QTY_VOLTAGE: reg_start = 8'h00;
      QTY_CURRENT: reg_start = 8'h01;
      QTY_POWER:   reg_start = 8'h02;
      default:     reg_start = 8'h04;
    endcase
    reg_count = (qty == QTY_POWER || qty == QTY_ENERGY) ? 8'h02 : 8'h01;
    head = {id, FN_READ_INPUT, 8'h00, reg_start, 8'h00, reg_count};
    crc = modbus_crc(head);
    frame = {head, crc[7:0], crc[15:8]};
    for (int i = 0; i < 8; i++) begin
      item.kind       = KIND_TX;
      item.tx_byte    = frame[(7 - i)*8 +: 8];
      item.frame_last = (i == 7);
      item.ok         = 1'b0;
      item.qty        = qty;
      item.raw        = 32'd0;
      awaited_results.push_back(item);
    end
    awaited_qty = qty;
    reply_len = 0;
  endtask

  task automatic predict_reading();
    meter_result_t item;
    item.kind       = KIND_READING;
    item.tx_byte    = 8'h00;
    item.frame_last = 1'b1;
    item.ok         = (reply_len > MIN_FAIL_COUNT);
    item.qty        = awaited_qty;
    item.raw        = 32'd0;
    if (item.ok) begin
      if (awaited_qty == QTY_POWER || awaited_qty == QTY_ENERGY) begin
        item.raw = {reply_bytes[3], reply_bytes[4], reply_bytes[5], reply_bytes[6]};
      end else begin
        item.raw = {16'h0000, reply_bytes[3], reply_bytes[4]};
      end
    end
    awaited_results.push_back(item);
    reply_len = 0;
  endtask

  task automatic absorb_request();
    case (request.func)
      FUNC_SEND: predict_request(request.quantity, request.device_id);
      FUNC_RX: begin
        if (reply_len < REPLY_SLOTS) begin
          reply_bytes[reply_len] = request.rx_byte;
        end
        if (request.rx_byte == LINE_FEED) begin
          predict_reading();
        end else if (reply_len < REPLY_SLOTS) begin
          reply_len++;
        end
      end
      FUNC_END: predict_reading();
      default: ;
    endcase
  endtask

  task automatic check_result();
    meter_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: kind %0d tx %02h value %08h",
                                result.kind, result.tx_byte, result.raw_value));
    end else begin
      want = awaited_results.pop_front();
      if (result.kind !== want.kind) begin
        report_mismatch($sformatf("kind %0d, expected %0d", result.kind, want.kind));
      end
      if (result.tx_byte !== want.tx_byte) begin
        report_mismatch($sformatf("tx_byte %02h, expected %02h", result.tx_byte, want.tx_byte));
      end
      if (result.frame_last !== want.frame_last) begin
        report_mismatch($sformatf("frame_last %0d, expected %0d", result.frame_last,
                                  want.frame_last));
      end
      if (result.ok !== want.ok) begin
        report_mismatch($sformatf("ok %0d, expected %0d", result.ok, want.ok));
      end
      if (result.reading_quantity !== want.qty) begin
        report_mismatch($sformatf("reading_quantity %0d, expected %0d",
                                  result.reading_quantity, want.qty));
      end
      if (result.raw_value !== want.raw) begin
        report_mismatch($sformatf("raw_value %08h, expected %08h", result.raw_value, want.raw));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      awaited_results.delete();
      for (int i = 0; i < REPLY_SLOTS; i++) begin
        reply_bytes[i] = 8'h00;
      end
      reply_len = 0;
      awaited_qty = QTY_VOLTAGE;
    end else begin
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        check_result();
      end
      if (request.valid === 1'b1 && request.ready === 1'b1) begin
        absorb_request();
      end
    end
    queued = awaited_results.size();
  end

endmodule

/* dv/testbench.sv */
// Top of the testbench: clock, reset, request stimulus, result stalls and the verdict.
`timescale 1ns / 100ps
module testbench;
  import mbrr_pkg::*;
  import meter_tb_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS  = 70;
  localparam int TOTAL_ITEMS  = 360;

  logic        clk = 1'b0;
  logic        rst;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_request = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned sent_items = 0;
  int unsigned error_count;
  int unsigned expected_count;

  mbrr_in_if  request_ch();
  mbrr_out_if result_ch();

  modbus_read_request_and_reply #(.REPLY_DEPTH(REPLY_SLOTS)) dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  meter_reply_checker reply_check (
    .clk            (clk),
    .rst            (rst),
    .request        (request_ch),
    .result         (result_ch),
    .error_count    (error_count),
    .expected_count (expected_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_taken = 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input logic [1:0] func, input logic [1:0] qty,
                           input logic [7:0] id, input logic [7:0] rx);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
    request_ch.valid     <= 1'b1;
    request_ch.func      <= func;
    request_ch.quantity  <= qty;
    request_ch.device_id <= id;
    request_ch.rx_byte   <= rx;
    @(posedge clk);
    while (request_ch.ready !== 1'b1) @(posedge clk);
    if (func != FUNC_IGNORED) begin
      sent_items++;
    end
  endtask

  task automatic send_rx(input logic [7:0] value);
    logic [31:0] r;
    r = $urandom;
    send_item(FUNC_RX, r[1:0], r[9:2], value);
  endtask

  task automatic reading_exchange();
    logic [31:0] r;
    logic [31:0] b;
    int unsigned len;
    r = $urandom;
    if ($urandom_range(0, 99) < 15) begin
      b = $urandom;
      send_item(r[1:0], r[3:2], r[11:4], b[7:0]);
      return;
    end
    b = $urandom;
    if ($urandom_range(0, 99) < 90) begin
      send_item(FUNC_SEND, r[1:0], r[9:2], b[7:0]);
    end
    if ($urandom_range(0, 99) < 15) begin
      len = $urandom_range(14, 20);
    end else if ($urandom_range(0, 99) < 20) begin
      len = $urandom_range(0, 5);
    end else begin
      len = $urandom_range(6, 9);
    end
    for (int i = 0; i < len; i++) begin
      b = $urandom;
      if (i == 0) begin
        send_rx(r[9:2]);
      end else if (i == 1) begin
        send_rx(FN_READ_INPUT);
      end else begin
        send_rx(b[7:0]);
      end
    end
    b = $urandom;
    if (r[31]) begin
      send_rx(LINE_FEED);
    end else begin
      send_item(FUNC_END, b[1:0], b[9:2], b[17:10]);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = sent_items + count;
    while (sent_items < stop_at) reading_exchange();
  endtask

  initial begin
    rst = 1'b1;
    request_ch.valid     = 1'b0;
    request_ch.func      = FUNC_IGNORED;
    request_ch.quantity  = QTY_VOLTAGE;
    request_ch.device_id = 8'h00;
    request_ch.rx_byte   = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A reply closed before any request reads as a failed voltage reading.
    send_item(FUNC_END, QTY_ENERGY, 8'h00, 8'h00);
    send_item(FUNC_IGNORED, QTY_POWER, 8'hFF, 8'hFF);
    send_item(FUNC_SEND, QTY_VOLTAGE, 8'hFF, 8'h00);
    send_rx(8'hFF);
    send_rx(FN_READ_INPUT);
    send_rx(8'h02);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'h80);
    send_item(FUNC_END, QTY_VOLTAGE, 8'h00, 8'hFF);
    send_item(FUNC_SEND, QTY_POWER, 8'h00, 8'hFF);
    send_rx(8'h00);
    send_rx(FN_READ_INPUT);
    send_rx(8'h04);
    send_rx(LINE_FEED);
    send_item(FUNC_SEND, QTY_CURRENT, 8'h01, 8'hFF);
    // Six bytes for energy leave the last byte of the value stale.
    send_item(FUNC_SEND, QTY_ENERGY, 8'h80, 8'h00);
    send_rx(8'h80);
    send_rx(FN_READ_INPUT);
    send_rx(8'h04);
    send_rx(8'hA5);
    send_rx(8'h5A);
    send_rx(8'h7F);
    send_item(FUNC_END, QTY_CURRENT, 8'h7F, 8'h01);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      run_random(PHASE_ITEMS);
    end

    send_idle_pct = 0;
    stall_pct = 10;
    hold_request = 1'b1;
    run_random(40);
    while (sent_items < TOTAL_ITEMS) reading_exchange();
    request_ch.valid <= 1'b0;

    @(posedge clk);
    while (expected_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: results still outstanding");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
